/* design/mtc_asm_pkg.sv */
// Shared types and constants for the MIDI time code assembler.
// Depends on nothing; every other design file refers to it by scoped names.
`default_nettype none

package mtc_asm_pkg;

  // Header bytes that a full-frame system exclusive message must carry.
  localparam logic [7:0] SxHeaderOne   = 8'h7F;
  localparam logic [7:0] SxHeaderTwo   = 8'h7F;
  localparam logic [7:0] SxHeaderThree = 8'h01;

  // Slots that end a forward or a backward run.
  localparam logic [2:0] SlotFirst = 3'd0;
  localparam logic [2:0] SlotLast  = 3'd7;

  // Request kinds.
  localparam logic ReqQuarterFrame = 1'b0;
  localparam logic ReqFullFrame    = 1'b1;

  // Divide by ten through a reciprocal: (v * 205) >> 11 is exact for v < 1029.
  localparam int unsigned DivTenMul   = 205;
  localparam int unsigned DivTenShift = 11;

  typedef struct packed {
    logic       req_type;
    logic [6:0] qf_byte;
    logic [7:0] sx_byte_one;
    logic [7:0] sx_byte_two;
    logic [7:0] sx_byte_three;
    logic [6:0] sx_hour_byte;
    logic [6:0] sx_minute_byte;
    logic [6:0] sx_second_byte;
    logic [6:0] sx_frame_byte;
  } mtc_in_t;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [4:0] minute_tens;
    logic [3:0] minute_ones;
    logic [4:0] second_tens;
    logic [3:0] second_ones;
    logic [4:0] frame_tens;
    logic [3:0] frame_ones;
    logic [1:0] rate_type;
    logic       from_full_frame;
  } mtc_out_t;

  // Time assembled from the quarter-frame slots for the item under evaluation.
  typedef struct packed {
    logic       emit;
    logic [4:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
    logic [7:0] frames;
    logic [1:0] rate;
  } mtc_qf_res_t;

endpackage

`default_nettype wire

/* design/mtc_asm_bcd_split.sv */
// Splits an 8-bit binary value into a tens value and a ones digit.
// Depends on mtc_asm_pkg for the reciprocal constants.
`default_nettype none

module mtc_asm_bcd_split (
  input  wire logic [7:0] value_i,
  output logic      [4:0] tens_o,
  output logic      [3:0] ones_o
);

  logic [15:0] prod;
  logic [4:0]  quot;
  logic [7:0]  back;
  logic [7:0]  rem;

  // Multiply by the reciprocal of ten, then subtract quotient times ten.
  assign prod   = 16'(value_i) * 16'(mtc_asm_pkg::DivTenMul);
  assign quot   = 5'(prod >> mtc_asm_pkg::DivTenShift);
  assign back   = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem    = value_i - back;
  assign tens_o = quot;
  assign ones_o = rem[3:0];

endmodule

`default_nettype wire

/* design/mtc_asm_slot_store.sv */
// Quarter-frame slot store, previous slot and playback direction tracking.
// Depends on mtc_asm_pkg for the result struct and slot constants.
`default_nettype none

module mtc_asm_slot_store (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     commit_i,
  input  wire logic [6:0]               qf_byte_i,
  output mtc_asm_pkg::mtc_qf_res_t      res_o
);

  logic [3:0] slot_q [8];
  logic [3:0] slot_d [8];
  logic [2:0] last_slot_q;
  logic       forward_q;
  logic       forward_d;
  logic [2:0] cur_slot;
  logic [3:0] cur_val;

  assign cur_slot = qf_byte_i[6:4];
  assign cur_val  = qf_byte_i[3:0];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      slot_d[i] = (cur_slot == 3'(i)) ? cur_val : slot_q[i];
    end
    // The direction holds whenever slot 7 is the current or the previous slot.
    if (cur_slot != mtc_asm_pkg::SlotLast && last_slot_q != mtc_asm_pkg::SlotLast) begin
      forward_d = (last_slot_q < cur_slot);
    end else begin
      forward_d = forward_q;
    end
    res_o.emit    = (forward_d && cur_slot == mtc_asm_pkg::SlotLast) ||
                    (!forward_d && cur_slot == mtc_asm_pkg::SlotFirst);
    res_o.hours   = {slot_d[7][0], slot_d[6]};
    res_o.minutes = {slot_d[5], slot_d[4]};
    res_o.seconds = {slot_d[3], slot_d[2]};
    res_o.frames  = {slot_d[1], slot_d[0]};
    res_o.rate    = slot_d[7][2:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        slot_q[i] <= 4'd0;
      end
      last_slot_q <= 3'd0;
      forward_q   <= 1'b0;
    end else if (commit_i) begin
      for (int i = 0; i < 8; i++) begin
        slot_q[i] <= slot_d[i];
      end
      last_slot_q <= cur_slot;
      forward_q   <= forward_d;
    end
  end

endmodule

`default_nettype wire

/* design/midi_timecode_assembler_unit.sv */
// MIDI time code assembler: input register, slot store, decimal split, result register.
// A transaction accepted into the input register is loaded into the result register
// once that register is empty or being drained, and its result is then offered.
// Throughput: one input transaction per cycle unless the result register is stalled; the
// decimal split is a small constant multiply between the input register and the result register.
// Reset clears both valid flags, all eight slot values, the previous slot and the direction.
`default_nettype none

module midi_timecode_assembler_unit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire mtc_asm_pkg::mtc_in_t  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output mtc_asm_pkg::mtc_out_t      out_data_o
);

  // Input register stage. It holds one accepted transaction until it can be
  // evaluated, which happens when the result register is empty or being drained.
  logic                   s1_valid_q;
  logic                   s1_valid_d;
  mtc_asm_pkg::mtc_in_t   s1_data_q;
  logic                   s1_adv;
  logic                   in_fire;

  // Result register stage.
  logic                   out_valid_q;
  logic                   out_valid_d;
  mtc_asm_pkg::mtc_out_t  out_data_q;
  mtc_asm_pkg::mtc_out_t  out_data_d;

  mtc_asm_pkg::mtc_qf_res_t qf_res;
  logic                     is_full;
  logic                     hdr_ok;
  logic                     emit;
  logic [7:0]               hours_sel;
  logic [7:0]               minutes_sel;
  logic [7:0]               seconds_sel;
  logic [7:0]               frames_sel;
  logic [1:0]               rate_sel;
  logic [4:0]               hour_tens_w;

  // The held transaction moves on whenever the result register can take a new value.
  // A transaction that produces no result still moves on; it simply leaves the
  // result register empty.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_full = (s1_data_q.req_type == mtc_asm_pkg::ReqFullFrame);
  assign hdr_ok  = (s1_data_q.sx_byte_one   == mtc_asm_pkg::SxHeaderOne) &&
                   (s1_data_q.sx_byte_two   == mtc_asm_pkg::SxHeaderTwo) &&
                   (s1_data_q.sx_byte_three == mtc_asm_pkg::SxHeaderThree);

  // The slot store only changes when a quarter-frame transaction is evaluated.
  // Full-frame messages never touch it, whether their header matches or not.
  mtc_asm_slot_store u_slot_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .commit_i  (s1_adv && !is_full),
    .qf_byte_i (s1_data_q.qf_byte),
    .res_o     (qf_res)
  );

  // Pick the time source: the full-frame bytes directly, or the assembled slots.
  always_comb begin
    if (is_full) begin
      hours_sel   = {3'b000, s1_data_q.sx_hour_byte[4:0]};
      minutes_sel = {1'b0, s1_data_q.sx_minute_byte};
      seconds_sel = {1'b0, s1_data_q.sx_second_byte};
      frames_sel  = {1'b0, s1_data_q.sx_frame_byte};
      rate_sel    = s1_data_q.sx_hour_byte[6:5];
      emit        = hdr_ok;
    end else begin
      hours_sel   = {3'b000, qf_res.hours};
      minutes_sel = qf_res.minutes;
      seconds_sel = qf_res.seconds;
      frames_sel  = qf_res.frames;
      rate_sel    = qf_res.rate;
      emit        = qf_res.emit;
    end
  end

  mtc_asm_bcd_split u_split_hour (
    .value_i (hours_sel),
    .tens_o  (hour_tens_w),
    .ones_o  (out_data_d.hour_ones)
  );

  mtc_asm_bcd_split u_split_minute (
    .value_i (minutes_sel),
    .tens_o  (out_data_d.minute_tens),
    .ones_o  (out_data_d.minute_ones)
  );

  mtc_asm_bcd_split u_split_second (
    .value_i (seconds_sel),
    .tens_o  (out_data_d.second_tens),
    .ones_o  (out_data_d.second_ones)
  );

  mtc_asm_bcd_split u_split_frame (
    .value_i (frames_sel),
    .tens_o  (out_data_d.frame_tens),
    .ones_o  (out_data_d.frame_ones)
  );

  // Hours never exceed 31, so the tens value fits in two bits.
  assign out_data_d.hour_tens       = hour_tens_w[1:0];
  assign out_data_d.rate_type       = rate_sel;
  assign out_data_d.from_full_frame = is_full;

  // Valid flags for both stages.
  always_comb begin
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end

    if (s1_adv) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset; they are qualified by the valid flags.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
    if (s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A blocked input means a transaction is held and the result register is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_o && !out_ready_i))
    else $error("input stalled without a stalled result");

  // Every ones digit leaving the block is a decimal digit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.hour_ones <= 4'd9 && out_data_o.minute_ones <= 4'd9 &&
                     out_data_o.second_ones <= 4'd9 && out_data_o.frame_ones <= 4'd9))
    else $error("ones digit out of range");

  // The minute, second and frame tens values never exceed 25, the tens of an 8-bit value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.minute_tens <= 5'd25 && out_data_o.second_tens <= 5'd25 &&
                     out_data_o.frame_tens <= 5'd25))
    else $error("tens value out of range");

endmodule

`default_nettype wire

/* tb/sv/midi_timecode_assembler_unit_tb.sv */
// Self-checking testbench for the MIDI time code assembler: quarter-frame runs in both
// directions, full-frame messages with good and broken headers, random stalls on both sides.
// Depends on mtc_asm_pkg and midi_timecode_assembler_unit.
module midi_timecode_assembler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest stretch of cycles without any transaction before the run is declared hung.
  // Sender gaps and receiver stalls stay far shorter than this, so it is ample.
  localparam int unsigned IdleLimit   = 2000;
  // Extra cycles after the last owed timecode, in which no further result may appear.
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned RandomItems = 900;
  localparam int unsigned InBits      = $bits(mtc_asm_pkg::mtc_in_t);

  // Tracks the quarter-frame slot store and the inferred direction, and holds the
  // timecodes that the block still owes us, oldest first.
  class timecode_tracker;
    logic [3:0]            slots [8];
    logic [2:0]            prev_slot;
    logic                  moving_forward;
    mtc_asm_pkg::mtc_out_t pending [$];
    int                    errors;

    function new();
      foreach (slots[i]) slots[i] = '0;
      prev_slot      = '0;
      moving_forward = 1'b0;
      errors         = 0;
    endfunction

    static function bit header_ok(mtc_asm_pkg::mtc_in_t t);
      return t.sx_byte_one == mtc_asm_pkg::SxHeaderOne &&
             t.sx_byte_two == mtc_asm_pkg::SxHeaderTwo &&
             t.sx_byte_three == mtc_asm_pkg::SxHeaderThree;
    endfunction

    // Every time field is split into tens and ones with no clamping.
    function mtc_asm_pkg::mtc_out_t split_time(int hours, int minutes, int seconds,
                                               int frames, logic [1:0] rate, logic full);
      mtc_asm_pkg::mtc_out_t o;
      o.hour_tens       = 2'(hours / 10);
      o.hour_ones       = 4'(hours % 10);
      o.minute_tens     = 5'(minutes / 10);
      o.minute_ones     = 4'(minutes % 10);
      o.second_tens     = 5'(seconds / 10);
      o.second_ones     = 4'(seconds % 10);
      o.frame_tens      = 5'(frames / 10);
      o.frame_ones      = 4'(frames % 10);
      o.rate_type       = rate;
      o.from_full_frame = full;
      return o;
    endfunction

    function void note_input(mtc_asm_pkg::mtc_in_t t);
      logic [2:0] slot;
      logic [3:0] s7;
      if (t.req_type == mtc_asm_pkg::ReqFullFrame) begin
        // A full frame bypasses the slot store entirely.
        if (header_ok(t)) begin
          pending.push_back(split_time(int'(t.sx_hour_byte[4:0]), int'(t.sx_minute_byte),
                                       int'(t.sx_second_byte), int'(t.sx_frame_byte),
                                       t.sx_hour_byte[6:5], 1'b1));
        end
      end else begin
        slot        = t.qf_byte[6:4];
        slots[slot] = t.qf_byte[3:0];
        // Slot 7 on either side keeps the current direction; equal slots mean backward.
        if (slot != mtc_asm_pkg::SlotLast && prev_slot != mtc_asm_pkg::SlotLast) begin
          moving_forward = prev_slot < slot;
        end
        if ((moving_forward && slot == mtc_asm_pkg::SlotLast) ||
            (!moving_forward && slot == mtc_asm_pkg::SlotFirst)) begin
          s7 = slots[mtc_asm_pkg::SlotLast];
          // Bit 3 of slot 7 plays no part in the rate.
          pending.push_back(split_time(int'({s7[0], slots[6]}), int'({slots[5], slots[4]}),
                                       int'({slots[3], slots[2]}), int'({slots[1], slots[0]}),
                                       s7[2:1], 1'b0));
        end
        prev_slot = slot;
      end
    endfunction

    function bit field_differs(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_result(mtc_asm_pkg::mtc_out_t r);
      mtc_asm_pkg::mtc_out_t e;
      bit                    bad;
      if (pending.size() == 0) begin
        $display("%0t: unexpected timecode %h", $time, r);
        errors++;
        return;
      end
      e   = pending.pop_front();
      bad = 1'b0;
      bad |= field_differs("hour_tens", 8'(e.hour_tens), 8'(r.hour_tens));
      bad |= field_differs("hour_ones", 8'(e.hour_ones), 8'(r.hour_ones));
      bad |= field_differs("minute_tens", 8'(e.minute_tens), 8'(r.minute_tens));
      bad |= field_differs("minute_ones", 8'(e.minute_ones), 8'(r.minute_ones));
      bad |= field_differs("second_tens", 8'(e.second_tens), 8'(r.second_tens));
      bad |= field_differs("second_ones", 8'(e.second_ones), 8'(r.second_ones));
      bad |= field_differs("frame_tens", 8'(e.frame_tens), 8'(r.frame_tens));
      bad |= field_differs("frame_ones", 8'(e.frame_ones), 8'(r.frame_ones));
      bad |= field_differs("rate_type", 8'(e.rate_type), 8'(r.rate_type));
      bad |= field_differs("from_full_frame", 8'(e.from_full_frame), 8'(r.from_full_frame));
      if (bad) errors++;
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready_o;
  mtc_asm_pkg::mtc_in_t  in_data   = '0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  mtc_asm_pkg::mtc_out_t out_data_o;

  timecode_tracker tracker = new();

  int unsigned idle_cycles  = 0;
  int unsigned useful_items = 0;
  int unsigned calm_left    = 0;

  midi_timecode_assembler_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Reset is held low from time zero and released at a rising edge, once.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Both handshakes are evaluated at the falling edge, after the testbench drives at the
  // rising edge and well after the block's outputs have settled. A transaction seen here
  // completes at the following rising edge. Inputs are noted before outputs are checked;
  // a result can never belong to an input that is only now being accepted.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) tracker.note_input(in_data);
      if (out_valid_o && out_ready) tracker.check_result(out_data_o);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : watchdog
    wait (rst_ni);
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
    $display("midi_timecode_assembler_unit_tb failed");
    $finish;
  end

  // Receiver side: mostly ready, with short stalls, the odd long stall and long
  // stretches of uninterrupted readiness.
  initial begin : result_sink
    int unsigned pick;
    int unsigned hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_ready <= 1'b1;
        hold = $urandom_range(1, 12);
      end else if (pick < 88) begin
        out_ready <= 1'b0;
        hold = $urandom_range(1, 3);
      end else if (pick < 94) begin
        out_ready <= 1'b0;
        hold = $urandom_range(10, 40);
      end else begin
        out_ready <= 1'b1;
        hold = $urandom_range(40, 100);
      end
      repeat (hold) @(posedge clk_i);
    end
  end

  // Idle cycles before the next input transaction: usually none or a few, sometimes
  // many, and now and then a calm stretch of back-to-back transactions.
  function automatic int unsigned sender_gap();
    int unsigned pick;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Quarter frame; the full-frame fields are don't-care and get random values.
  function automatic mtc_asm_pkg::mtc_in_t quarter_frame(logic [2:0] slot, logic [3:0] nib);
    mtc_asm_pkg::mtc_in_t t;
    t = InBits'({$urandom, $urandom});
    t.req_type = mtc_asm_pkg::ReqQuarterFrame;
    t.qf_byte  = {slot, nib};
    return t;
  endfunction

  function automatic mtc_asm_pkg::mtc_in_t full_frame(logic [7:0] one, logic [7:0] two,
                                                      logic [7:0] three, logic [6:0] hb,
                                                      logic [6:0] mb, logic [6:0] sb,
                                                      logic [6:0] fb);
    mtc_asm_pkg::mtc_in_t t;
    t.req_type       = mtc_asm_pkg::ReqFullFrame;
    t.qf_byte        = 7'($urandom);
    t.sx_byte_one    = one;
    t.sx_byte_two    = two;
    t.sx_byte_three  = three;
    t.sx_hour_byte   = hb;
    t.sx_minute_byte = mb;
    t.sx_second_byte = sb;
    t.sx_frame_byte  = fb;
    return t;
  endfunction

  // Called at a rising edge; returns at the rising edge where the transaction completes.
  // Valid is lowered only when a gap follows, so it is never dropped and raised in one step.
  task automatic send_item(mtc_asm_pkg::mtc_in_t t);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    if (t.req_type == mtc_asm_pkg::ReqQuarterFrame || timecode_tracker::header_ok(t)) begin
      useful_items++;
    end
  endtask

  // Consecutive slots from first to last, ascending or descending, with random values.
  task automatic send_run(int first, int last);
    int s;
    s = first;
    forever begin
      send_item(quarter_frame(3'(s), 4'($urandom)));
      if (s == last) break;
      s = (last > first) ? s + 1 : s - 1;
    end
  endtask

  initial begin : stimulus
    int unsigned pick;
    int          s;
    wait (rst_ni);
    @(posedge clk_i);

    // Full frames at both extremes of every time byte, then one header byte wrong at a time.
    send_item(full_frame(mtc_asm_pkg::SxHeaderOne, mtc_asm_pkg::SxHeaderTwo,
                         mtc_asm_pkg::SxHeaderThree, '0, '0, '0, '0));
    send_item(full_frame(mtc_asm_pkg::SxHeaderOne, mtc_asm_pkg::SxHeaderTwo,
                         mtc_asm_pkg::SxHeaderThree, '1, '1, '1, '1));
    send_item(full_frame(8'h7E, mtc_asm_pkg::SxHeaderTwo,
                         mtc_asm_pkg::SxHeaderThree, '1, '1, '1, '1));
    send_item(full_frame(mtc_asm_pkg::SxHeaderOne, 8'hFF,
                         mtc_asm_pkg::SxHeaderThree, '1, '1, '1, '1));
    send_item(full_frame(mtc_asm_pkg::SxHeaderOne, mtc_asm_pkg::SxHeaderTwo,
                         8'h00, '1, '1, '1, '1));

    // Forward run with every nibble at its maximum, so slot 7 has bit 3 set; then a
    // backward run of zeros. Going from slot 7 down to 6 keeps the direction.
    for (s = 0; s < 8; s++) send_item(quarter_frame(3'(s), 4'hF));
    for (s = 7; s >= 0; s--) send_item(quarter_frame(3'(s), 4'h0));

    // The same slot twice reads as backward.
    send_item(quarter_frame(3'd3, 4'h9));
    send_item(quarter_frame(3'd3, 4'h6));
    send_item(quarter_frame(3'd0, 4'h5));

    useful_items = 0;
    while (useful_items < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        send_run($urandom_range(0, 2) == 0 ? $urandom_range(0, 6) : 0, 7);
      end else if (pick < 62) begin
        send_run($urandom_range(0, 2) == 0 ? $urandom_range(1, 7) : 7, 0);
      end else if (pick < 76) begin
        send_item(full_frame(mtc_asm_pkg::SxHeaderOne, mtc_asm_pkg::SxHeaderTwo,
                             mtc_asm_pkg::SxHeaderThree, 7'($urandom),
                             7'($urandom), 7'($urandom), 7'($urandom)));
      end else if (pick < 86) begin
        send_item(quarter_frame(3'($urandom), 4'($urandom)));
      end else if (pick < 94) begin
        // A run that breaks off part way and turns around.
        s = $urandom_range(1, 6);
        send_run($urandom_range(0, s - 1), s);
        send_run(s, $urandom_range(0, s));
      end else if (pick < 97) begin
        send_item(full_frame(
            $urandom_range(0, 1) ? mtc_asm_pkg::SxHeaderOne : 8'($urandom),
            $urandom_range(0, 1) ? mtc_asm_pkg::SxHeaderTwo : 8'($urandom),
            $urandom_range(0, 1) ? mtc_asm_pkg::SxHeaderThree : 8'($urandom),
            7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom)));
      end else begin
        send_item(full_frame(8'($urandom), 8'($urandom), 8'($urandom), 7'($urandom),
                             7'($urandom), 7'($urandom), 7'($urandom)));
      end
    end
    in_valid <= 1'b0;

    // Every owed timecode must come back, and nothing extra may follow.
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("midi_timecode_assembler_unit_tb passed");
    end else begin
      $display("midi_timecode_assembler_unit_tb failed");
    end
    $finish;
  end

endmodule
